// ----- src/iqrd_pkg.sv -----
// Shared types, constants and helpers for the IQ readout discriminator.
`timescale 1ns / 1ps
package iqrd_pkg;

  localparam int unsigned DEF_MAX_POINTS  = 1024;
  localparam int unsigned DEF_SAMPLE_BITS = 16;
  localparam int unsigned N_CH            = 4;
  localparam int unsigned ACC_W           = 48;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned DIV_STEPS       = ACC_W;
  localparam int unsigned FRAC_SHIFT      = 16;
  localparam int unsigned QDEPTH          = 2;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_N_POINTS = 3'd0;
  localparam logic [2:0] CFG_ACTIVE   = 3'd1;
  localparam logic [2:0] CFG_COS_A    = 3'd2;
  localparam logic [2:0] CFG_SIN_A    = 3'd3;
  localparam logic [2:0] CFG_COS_B    = 3'd4;
  localparam logic [2:0] CFG_SIN_B    = 3'd5;

  localparam logic [10:0] RST_N_POINTS = 11'd1024;
  localparam logic [3:0]  RST_ACTIVE   = 4'd15;
  localparam logic [15:0] RST_COS      = 16'd32767;
  localparam logic [15:0] RST_SIN      = 16'd0;

  // probability selectors
  localparam logic [9:0] SEL_PA       = 10'd0;
  localparam logic [9:0] SEL_PB       = 10'd1;
  localparam logic [9:0] SEL_JOINT_LO = 10'd2;
  localparam logic [9:0] SEL_LIMIT    = 10'd6;

  typedef enum logic [1:0] {
    K_SAMPLE    = 2'd0,
    K_CLEAR     = 2'd1,
    K_READ_AVG  = 2'd2,
    K_READ_PROB = 2'd3
  } in_kind_e;

  typedef enum logic [1:0] {
    R_SUMMARY = 2'd0,
    R_POINT   = 2'd1,
    R_PROB    = 2'd2
  } res_kind_e;

  typedef enum logic [2:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_RMW,
    FS_PROD,
    FS_DEC,
    FS_RDP,
    FS_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIV,
    BS_OUT
  } back_state_e;

  typedef struct packed {
    logic [10:0]        n_points;
    logic [3:0]         active;
    logic signed [15:0] cos_a;
    logic signed [15:0] sin_a;
    logic signed [15:0] cos_b;
    logic signed [15:0] sin_b;
  } cfg_t;

  // one division job handed from front to back
  typedef struct packed {
    res_kind_e                   kind;
    logic [N_CH-1:0]             neg;
    logic [N_CH-1:0][ACC_W-1:0]  mag;
    logic [CNT_W-1:0]            divisor;
    logic                        sw_a;
    logic                        sw_b;
    logic [CNT_W-1:0]            total;
  } job_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + CNT_W'(1);
  endfunction

endpackage

// ----- src/iqrd_front.sv -----
// Front end: accepts items, keeps sums, accumulators and counts, issues division jobs.
`timescale 1ns / 1ps
module iqrd_front
  import iqrd_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = DEF_MAX_POINTS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  in_kind_e    kind_i,
  input  logic [15:0] sample_one_i,
  input  logic [15:0] sample_two_i,
  input  logic [15:0] sample_three_i,
  input  logic [15:0] sample_four_i,
  input  logic [9:0]  read_index_i,
  output logic        push_o,
  output job_t        job_o,
  input  logic        full_i
);

  localparam int unsigned AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned SUMW = SAMPLE_BITS + AW + 1;
  localparam int unsigned PRW  = SUMW + 16;
  localparam int unsigned CW   = PRW + 1;

  front_state_e state_q, state_d;

  logic [N_CH-1:0][ACC_W-1:0] acc_mem [MAX_POINTS];
  logic [N_CH-1:0][ACC_W-1:0] rd_q;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [N_CH-1:0][ACC_W-1:0] mem_wdata;

  logic [AW-1:0]  pos_q, pos_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic signed [SUMW-1:0] sum_q [N_CH];
  logic signed [SUMW-1:0] sum_d [N_CH];
  logic signed [SAMPLE_BITS-1:0] smp_q [N_CH];
  logic signed [PRW-1:0] prod_q [N_CH];
  logic signed [PRW-1:0] prod_d [N_CH];
  logic [CNT_W-1:0] seg_cnt_q, seg_cnt_d;
  logic [CNT_W-1:0] sw_cnt_q [2];
  logic [CNT_W-1:0] sw_cnt_d [2];
  logic [CNT_W-1:0] jt_cnt_q [4];
  logic [CNT_W-1:0] jt_cnt_d [4];
  logic [9:0]       ri_q;
  logic             ri_ok_q;
  logic             kind_q_is_avg;
  job_t             job_q, job_d;

  logic        accept;
  logic [31:0] eff_pts, taken, ri32;
  logic        seg_end;
  logic signed [CW-1:0] rot_a, rot_b;
  logic        dec_a, dec_b;
  logic [CNT_W-1:0] sel_cnt;
  logic [ACC_W-1:0] rd_abs;

  assign accept  = valid_i && ready_o;
  assign ready_o = (state_q == FS_IDLE);
  assign ri32    = 32'(read_index_i);

  always_comb begin
    if (cfg_i.n_points == 11'd0) begin
      eff_pts = 32'd1;
    end else if (32'(cfg_i.n_points) > MAX_POINTS) begin
      eff_pts = MAX_POINTS;
    end else begin
      eff_pts = 32'(cfg_i.n_points);
    end
  end

  assign taken   = 32'(pos_q) + 32'd1;
  assign seg_end = (taken >= eff_pts);
  assign rot_a   = CW'(prod_q[0]) + CW'(prod_q[1]);
  assign rot_b   = CW'(prod_q[2]) + CW'(prod_q[3]);
  assign dec_a   = (cfg_i.active[1:0] == 2'b11) && (rot_a > 0);
  assign dec_b   = (cfg_i.active[3:2] == 2'b11) && (rot_b > 0);

  // accumulator memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      acc_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_q <= acc_mem[mem_raddr];
    end
  end

  assign mem_raddr = (kind_i == K_READ_AVG) ? ri32[AW-1:0] : pos_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = '0;
    if (state_q == FS_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (state_q == FS_RMW) begin
      mem_we = 1'b1;
      for (int k = 0; k < N_CH; k++) begin
        mem_wdata[k] = rd_q[k] + ACC_W'(smp_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q[0] <= sample_one_i[SAMPLE_BITS-1:0];
      smp_q[1] <= sample_two_i[SAMPLE_BITS-1:0];
      smp_q[2] <= sample_three_i[SAMPLE_BITS-1:0];
      smp_q[3] <= sample_four_i[SAMPLE_BITS-1:0];
      ri_q     <= read_index_i;
      ri_ok_q  <= (ri32 < MAX_POINTS);
    end
    for (int k = 0; k < N_CH; k++) begin
      prod_q[k] <= prod_d[k];
    end
    job_q <= job_d;
  end

  always_comb begin
    prod_d[0] = sum_q[0] * cfg_i.cos_a;
    prod_d[1] = sum_q[1] * cfg_i.sin_a;
    prod_d[2] = sum_q[2] * cfg_i.cos_b;
    prod_d[3] = sum_q[3] * cfg_i.sin_b;
  end

  always_comb begin
    if (ri_q < SEL_JOINT_LO) begin
      sel_cnt = sw_cnt_q[ri_q[0]];
    end else if (ri_q < SEL_LIMIT) begin
      sel_cnt = jt_cnt_q[2'(ri_q - SEL_JOINT_LO)];
    end else begin
      sel_cnt = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FS_CLEAR;
      pos_q     <= '0;
      clr_q     <= '0;
      seg_cnt_q <= '0;
      for (int k = 0; k < N_CH; k++) begin
        sum_q[k]    <= '0;
        jt_cnt_q[k] <= '0;
      end
      sw_cnt_q[0] <= '0;
      sw_cnt_q[1] <= '0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      clr_q     <= clr_d;
      seg_cnt_q <= seg_cnt_d;
      for (int k = 0; k < N_CH; k++) begin
        sum_q[k]    <= sum_d[k];
        jt_cnt_q[k] <= jt_cnt_d[k];
      end
      sw_cnt_q[0] <= sw_cnt_d[0];
      sw_cnt_q[1] <= sw_cnt_d[1];
    end
  end

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    clr_d     = clr_q;
    seg_cnt_d = seg_cnt_q;
    sum_d     = sum_q;
    sw_cnt_d  = sw_cnt_q;
    jt_cnt_d  = jt_cnt_q;
    job_d     = job_q;
    push_o    = 1'b0;
    rd_abs    = '0;
    unique case (state_q)
      FS_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (32'(clr_q) == MAX_POINTS - 1) begin
          clr_d   = '0;
          state_d = FS_IDLE;
        end
      end
      FS_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            K_SAMPLE: state_d = FS_RMW;
            K_CLEAR: begin
              pos_d     = '0;
              seg_cnt_d = '0;
              for (int k = 0; k < N_CH; k++) begin
                sum_d[k]    = '0;
                jt_cnt_d[k] = '0;
              end
              sw_cnt_d[0] = '0;
              sw_cnt_d[1] = '0;
              state_d     = FS_CLEAR;
            end
            K_READ_AVG:  state_d = FS_RDP;
            K_READ_PROB: state_d = FS_RDP;
            default:     state_d = FS_IDLE;
          endcase
        end
      end
      FS_RMW: begin
        for (int k = 0; k < N_CH; k++) begin
          sum_d[k] = sum_q[k] + SUMW'(smp_q[k]);
        end
        if (seg_end) begin
          state_d = FS_PROD;
        end else begin
          pos_d   = pos_q + AW'(1);
          state_d = FS_IDLE;
        end
      end
      FS_PROD: state_d = FS_DEC;
      FS_DEC: begin
        seg_cnt_d = sat_inc(seg_cnt_q);
        if (dec_a) sw_cnt_d[0] = sat_inc(sw_cnt_q[0]);
        if (dec_b) sw_cnt_d[1] = sat_inc(sw_cnt_q[1]);
        if (cfg_i.active == 4'hF) begin
          jt_cnt_d[{dec_a, dec_b}] = sat_inc(jt_cnt_q[{dec_a, dec_b}]);
        end
        job_d.kind    = R_SUMMARY;
        job_d.divisor = taken;
        job_d.sw_a    = dec_a;
        job_d.sw_b    = dec_b;
        job_d.total   = sat_inc(seg_cnt_q);
        for (int k = 0; k < N_CH; k++) begin
          job_d.neg[k] = sum_q[k][SUMW-1];
          job_d.mag[k] = sum_q[k][SUMW-1] ? ACC_W'(SUMW'(-sum_q[k])) : ACC_W'(sum_q[k]);
          sum_d[k]     = '0;
        end
        pos_d   = '0;
        state_d = FS_PUSH;
      end
      FS_RDP: begin
        job_d.sw_a    = 1'b0;
        job_d.sw_b    = 1'b0;
        job_d.total   = seg_cnt_q;
        job_d.divisor = (seg_cnt_q == '0) ? CNT_W'(1) : seg_cnt_q;
        job_d.neg     = '0;
        job_d.mag     = '0;
        state_d       = FS_PUSH;
        // a read item that is not a point average is a probability read
        if (kind_q_is_avg) begin
          job_d.kind = R_POINT;
          if (ri_ok_q && seg_cnt_q != '0) begin
            for (int k = 0; k < N_CH; k++) begin
              rd_abs       = rd_q[k][ACC_W-1] ? -rd_q[k] : rd_q[k];
              job_d.neg[k] = rd_q[k][ACC_W-1];
              job_d.mag[k] = rd_abs;
            end
          end
        end else begin
          job_d.kind = R_PROB;
          if (seg_cnt_q != '0) begin
            job_d.mag[0] = {sel_cnt[ACC_W-FRAC_SHIFT-1:0], FRAC_SHIFT'(0)};
          end
        end
      end
      FS_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q_is_avg <= (kind_i == K_READ_AVG);
    end
  end

  assign job_o = job_q;

endmodule

// ----- src/iqrd_queue.sv -----
// Two-entry job queue between the front and the divider back end.
`timescale 1ns / 1ps
module iqrd_queue
  import iqrd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  job_t       slot_q [QDEPTH];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(QDEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- src/iqrd_back.sv -----
// Back end: four-lane restoring divider, clamping and the output register.
`timescale 1ns / 1ps
module iqrd_back
  import iqrd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  job_t         job_i,
  input  logic         empty_i,
  output logic         pop_o,
  output logic         valid_o,
  input  logic         ready_i,
  output res_kind_e    kind_o,
  output logic [119:0] data_o
);

  localparam int unsigned STW = $clog2(DIV_STEPS + 1);

  back_state_e state_q, state_d;
  job_t        job_q;
  logic [CNT_W:0]             rem_q [N_CH];
  logic [CNT_W:0]             rem_d [N_CH];
  logic [N_CH-1:0][ACC_W-1:0] dq_q, dq_d;
  logic [STW-1:0]             step_q, step_d;
  logic [N_CH-1:0][15:0]      mean;
  logic [16:0]                frac;
  logic [CNT_W:0]             trial;

  always_comb begin
    trial = '0;
    for (int k = 0; k < N_CH; k++) begin
      trial    = {rem_q[k][CNT_W-1:0], dq_q[k][ACC_W-1]};
      rem_d[k] = trial;
      dq_d[k]  = {dq_q[k][ACC_W-2:0], 1'b0};
      if (trial >= {1'b0, job_q.divisor}) begin
        rem_d[k]   = trial - {1'b0, job_q.divisor};
        dq_d[k][0] = 1'b1;
      end
    end
  end

  // clamp quotients to the signed 16-bit range, or to one for probabilities
  always_comb begin
    for (int k = 0; k < N_CH; k++) begin
      if (job_q.kind == R_PROB) begin
        mean[k] = '0;
      end else if (job_q.neg[k]) begin
        mean[k] = (dq_q[k] > ACC_W'(32768)) ? 16'h8000 : 16'(-dq_q[k][15:0]);
      end else begin
        mean[k] = (dq_q[k] > ACC_W'(32767)) ? 16'h7FFF : dq_q[k][15:0];
      end
    end
    if (job_q.kind != R_PROB) begin
      frac = '0;
    end else if (dq_q[0] > ACC_W'(65536)) begin
      frac = 17'h10000;
    end else begin
      frac = dq_q[0][16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BS_IDLE && !empty_i) begin
      job_q <= job_i;
      dq_q  <= job_i.mag;
      for (int k = 0; k < N_CH; k++) rem_q[k] <= '0;
    end else if (state_q == BS_DIV) begin
      dq_q <= dq_d;
      for (int k = 0; k < N_CH; k++) rem_q[k] <= rem_d[k];
    end
    if (state_q == BS_DIV && step_q == STW'(DIV_STEPS - 1)) begin
      kind_o <= job_q.kind;
    end
    if (state_q == BS_DIV && step_q == STW'(DIV_STEPS)) begin
      data_o <= {5'd0, job_q.total, frac, job_q.sw_b, job_q.sw_a,
                 mean[3], mean[2], mean[1], mean[0]};
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    pop_o   = 1'b0;
    valid_o = 1'b0;
    unique case (state_q)
      BS_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          step_d  = '0;
          state_d = BS_DIV;
        end
      end
      BS_DIV: begin
        // one quotient bit per cycle, then the output register is loaded
        step_d = step_q + STW'(1);
        if (step_q == STW'(DIV_STEPS)) begin
          state_d = BS_OUT;
        end
      end
      BS_OUT: begin
        valid_o = 1'b1;
        if (ready_i) state_d = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

endmodule

// ----- src/iq_readout_discriminator.sv -----
// Top level of the IQ readout discriminator: configuration registers and wiring.
`timescale 1ns / 1ps
// One item carries a time point of four channels, a clear, or a read. A sample is a
// read-modify-write of the accumulator memory, read on accept and written in FS_RMW;
// the item that ends a segment goes on through FS_PROD and FS_DEC, for the rotation
// products and the decision. Every item that gives a result hands a job through a
// two-entry queue to a four-lane restoring divider that takes a job only after the last
// one's output handshake; the front stalls once the queue is full. After reset and after
// each clear item the accumulator memory is swept to zero, during which no item is accepted.
module iq_readout_discriminator
  import iqrd_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = DEF_MAX_POINTS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sample_one, sample_two, sample_three, sample_four, read_index, zero fill
  input  logic [79:0]  s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mean_one, mean_two, mean_three, mean_four, switched_a, switched_b,
  // fraction, segment_total, zero fill
  output logic [119:0] m_axis_tdata,
  // result_kind
  output logic [1:0]   m_axis_tuser
);

  cfg_t      cfg_q;
  logic      push, full, pop, empty;
  job_t      push_job, pop_job;
  res_kind_e out_kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.n_points <= RST_N_POINTS;
      cfg_q.active   <= RST_ACTIVE;
      cfg_q.cos_a    <= RST_COS;
      cfg_q.sin_a    <= RST_SIN;
      cfg_q.cos_b    <= RST_COS;
      cfg_q.sin_b    <= RST_SIN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_N_POINTS: cfg_q.n_points <= cfg_data_i[10:0];
        CFG_ACTIVE:   cfg_q.active   <= cfg_data_i[3:0];
        CFG_COS_A:    cfg_q.cos_a    <= cfg_data_i;
        CFG_SIN_A:    cfg_q.sin_a    <= cfg_data_i;
        CFG_COS_B:    cfg_q.cos_b    <= cfg_data_i;
        CFG_SIN_B:    cfg_q.sin_b    <= cfg_data_i;
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  iqrd_front #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .kind_i         (in_kind_e'(s_axis_tuser)),
    .sample_one_i   (s_axis_tdata[15:0]),
    .sample_two_i   (s_axis_tdata[31:16]),
    .sample_three_i (s_axis_tdata[47:32]),
    .sample_four_i  (s_axis_tdata[63:48]),
    .read_index_i   (s_axis_tdata[73:64]),
    .push_o         (push),
    .job_o          (push_job),
    .full_i         (full)
  );

  iqrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (empty)
  );

  iqrd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (pop_job),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .kind_o  (out_kind),
    .data_o  (m_axis_tdata)
  );

  assign m_axis_tuser = out_kind;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the IQ readout discriminator stream block.
`timescale 1ns / 1ps
module tb;
  import iqrd_pkg::*;

  localparam int unsigned NPT = DEF_MAX_POINTS;
  localparam int unsigned QUIET_LIMIT = 20000;

  typedef struct {
    in_kind_e           kind;
    logic signed [15:0] smp [4];
    logic [9:0]         ridx;
  } sample_item_t;

  typedef struct {
    res_kind_e          rkind;
    logic [15:0]        mean [4];
    logic               sw_a;
    logic               sw_b;
    logic [16:0]        frac;
    logic [31:0]        total;
  } readout_t;

  class readout_scoreboard;
    logic [10:0]        npts;
    logic [3:0]         active;
    logic signed [15:0] cos_a, sin_a, cos_b, sin_b;
    int unsigned        ppos;
    longint             seg_sum [4];
    logic [47:0]        acc [4][NPT];
    logic [31:0]        seg_cnt;
    logic [31:0]        sw_cnt [2];
    logic [31:0]        joint_cnt [4];
    readout_t           expected_q [$];
    int                 errors;

    function new();
      npts = RST_N_POINTS;
      active = RST_ACTIVE;
      cos_a = RST_COS;
      sin_a = RST_SIN;
      cos_b = RST_COS;
      sin_b = RST_SIN;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      ppos = 0;
      seg_cnt = 0;
      for (int k = 0; k < 4; k++) begin
        seg_sum[k] = 0;
        joint_cnt[k] = 0;
        for (int p = 0; p < NPT; p++) acc[k][p] = '0;
      end
      sw_cnt[0] = 0;
      sw_cnt[1] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_N_POINTS: npts = val[10:0];
        CFG_ACTIVE:   active = val[3:0];
        CFG_COS_A:    cos_a = val;
        CFG_SIN_A:    sin_a = val;
        CFG_COS_B:    cos_b = val;
        CFG_SIN_B:    sin_b = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] bump(logic [31:0] c);
      return (c == '1) ? c : c + 32'd1;
    endfunction

    function logic [15:0] clamp(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Advance the discriminator state for one accepted item.
    function void note_input(sample_item_t it);
      readout_t r;
      int unsigned pos, eff, taken;
      longint rot, a;
      logic [63:0] cnt, f;
      r.rkind = R_SUMMARY;
      for (int k = 0; k < 4; k++) r.mean[k] = '0;
      r.sw_a = 0;
      r.sw_b = 0;
      r.frac = '0;
      case (it.kind)
        K_CLEAR: begin
          wipe();
          return;
        end
        K_SAMPLE: begin
          pos = (ppos >= NPT) ? NPT - 1 : ppos;
          for (int k = 0; k < 4; k++) begin
            seg_sum[k] += longint'(it.smp[k]);
            acc[k][pos] = acc[k][pos] + {{32{it.smp[k][15]}}, it.smp[k]};
          end
          eff = (npts == 0) ? 1 : (npts > NPT) ? NPT : npts;
          if (pos + 1 < eff) begin
            ppos = pos + 1;
            return;
          end
          taken = pos + 1;
          if (active[1:0] == 2'b11) begin
            rot = seg_sum[0] * longint'(cos_a) + seg_sum[1] * longint'(sin_a);
            if (rot > 0) begin
              r.sw_a = 1;
              sw_cnt[0] = bump(sw_cnt[0]);
            end
          end
          if (active[3:2] == 2'b11) begin
            rot = seg_sum[2] * longint'(cos_b) + seg_sum[3] * longint'(sin_b);
            if (rot > 0) begin
              r.sw_b = 1;
              sw_cnt[1] = bump(sw_cnt[1]);
            end
          end
          if (active == 4'hF) joint_cnt[{r.sw_a, r.sw_b}] = bump(joint_cnt[{r.sw_a, r.sw_b}]);
          seg_cnt = bump(seg_cnt);
          for (int k = 0; k < 4; k++) begin
            r.mean[k] = clamp(seg_sum[k] / longint'(taken));
            seg_sum[k] = 0;
          end
          ppos = 0;
        end
        K_READ_AVG: begin
          r.rkind = R_POINT;
          if (seg_cnt != 0)
            for (int k = 0; k < 4; k++) begin
              a = {{16{acc[k][it.ridx][47]}}, acc[k][it.ridx]};
              r.mean[k] = clamp(a / longint'({32'd0, seg_cnt}));
            end
        end
        default: begin
          r.rkind = R_PROB;
          cnt = 0;
          if (it.ridx < SEL_JOINT_LO) cnt = 64'(sw_cnt[it.ridx[0]]);
          else if (it.ridx < SEL_LIMIT) cnt = 64'(joint_cnt[it.ridx - SEL_JOINT_LO]);
          f = 0;
          if (seg_cnt != 0) begin
            f = (cnt << 16) / {32'd0, seg_cnt};
            if (f > 65536) f = 65536;
          end
          r.frac = f[16:0];
        end
      endcase
      r.total = seg_cnt;
      expected_q = {expected_q, r};
    endfunction

    task check_result(readout_t got);
      readout_t w;
      if (expected_q.size() == 0) begin
        report("unexpected result", got.rkind, -1);
        return;
      end
      w = expected_q.pop_front();
      if (got.rkind != w.rkind) report("result_kind", got.rkind, w.rkind);
      for (int k = 0; k < 4; k++)
        if (got.mean[k] !== w.mean[k])
          report($sformatf("mean[%0d]", k), $signed(got.mean[k]), $signed(w.mean[k]));
      if (got.sw_a !== w.sw_a) report("switched_a", got.sw_a, w.sw_a);
      if (got.sw_b !== w.sw_b) report("switched_b", got.sw_b, w.sw_b);
      if (got.frac !== w.frac) report("fraction", got.frac, w.frac);
      if (got.total !== w.total) report("segment_total", got.total, w.total);
    endtask
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_index_i;
  logic [15:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [119:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  readout_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int quiet_cycles;

  iq_readout_discriminator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: check on handshake, then pick next tready.
  initial begin
    int hold_left;
    readout_t got;
    hold_left = 0;
    m_axis_tready = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready && rst_ni) begin
        got.rkind = res_kind_e'(m_axis_tuser);
        for (int k = 0; k < 4; k++) got.mean[k] = m_axis_tdata[16*k +: 16];
        got.sw_a = m_axis_tdata[64];
        got.sw_b = m_axis_tdata[65];
        got.frac = m_axis_tdata[82:66];
        got.total = m_axis_tdata[114:83];
        sb.check_result(got);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else if (++quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send(sample_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= it.kind;
    s_axis_tdata <= {6'd0, it.ridx, it.smp[3], it.smp[2], it.smp[1], it.smp[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(it);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Wait out any clear sweep before touching registers.
  task automatic set_regs(logic [10:0] n, logic [3:0] act, logic [15:0] ca, logic [15:0] sa,
                          logic [15:0] cb, logic [15:0] sbv);
    logic [15:0] vals [6];
    drain();
    repeat (1100) @(posedge clk_i);
    vals = '{16'(n), 16'(act), ca, sa, cb, sbv};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1;
      cfg_index_i <= 3'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(3'(i), vals[i]);
    end
    cfg_we_i <= 0;
  endtask

  function automatic sample_item_t make(in_kind_e kind, int s0, int s1, int s2, int s3,
                                        int ridx);
    sample_item_t it;
    it.kind = kind;
    it.smp[0] = 16'(s0);
    it.smp[1] = 16'(s1);
    it.smp[2] = 16'(s2);
    it.smp[3] = 16'(s3);
    it.ridx = 10'(ridx);
    return it;
  endfunction

  function automatic sample_item_t random_item();
    sample_item_t it;
    int pick;
    pick = $urandom_range(99);
    it = make(K_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(9) == 0)
      for (int k = 0; k < 4; k++) it.smp[k] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    if (pick >= 98) it.kind = K_CLEAR;
    else if (pick >= 86) it.kind = K_READ_AVG;
    else if (pick >= 74) begin
      it.kind = K_READ_PROB;
      if ($urandom_range(9) != 0) it.ridx = 10'($urandom_range(7));
    end
    return it;
  endfunction

  task automatic random_run(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send(random_item());
  endtask

  initial begin
    sb = new();
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = K_SAMPLE;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: zero point count acts as one, so every sample closes a segment.
    set_regs(11'd0, 4'hF, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000);
    send(make(K_READ_AVG, 0, 0, 0, 0, 0));
    send(make(K_READ_PROB, 0, 0, 0, 0, 0));
    send(make(K_SAMPLE, 32767, 32767, 32767, 32767, 1023));
    send(make(K_SAMPLE, -32768, -32768, -32768, -32768, 0));
    send(make(K_SAMPLE, 32767, -32768, -1, 1, 0));
    send(make(K_SAMPLE, 0, 0, 0, 0, 0));
    send(make(K_READ_AVG, 0, 0, 0, 0, 0));
    send(make(K_READ_AVG, 0, 0, 0, 0, 1023));
    for (int i = 0; i < 8; i++) send(make(K_READ_PROB, 0, 0, 0, 0, i));
    send(make(K_READ_PROB, 0, 0, 0, 0, 1023));
    send(make(K_CLEAR, 0, 0, 0, 0, 0));
    send(make(K_READ_PROB, 0, 0, 0, 0, 0));
    send(make(K_READ_AVG, 0, 0, 0, 0, 0));

    // Extreme rotations, all channels active, no idling.
    set_regs(11'd1, 4'hF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
    random_run(150, 0, 0);

    // Hold off the result side so the job queue fills and the input stalls.
    hold_request = 400;
    repeat (20) send(make(K_SAMPLE, $urandom, $urandom, $urandom, $urandom, 0));
    drain();

    set_regs(11'd3, 4'h3, 16'h5A82, 16'hA57E, 16'h0000, 16'h7FFF);
    random_run(180, 75, 0);

    set_regs(11'd2, 4'hC, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_run(180, 0, 75);

    // Largest point count; then lower it mid-segment so the next sample ends it.
    set_regs(11'd2047, 4'hF, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_run(40, 0, 0);
    set_regs(11'd5, 4'hF, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_run(180, 24, 24);

    set_regs(11'd1024, 4'h0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_run(20, 0, 0);
    set_regs(11'd4, 4'h5, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_run(100, 24, 24);
    set_regs(11'd1, 4'hF, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_run(160, 0, 0);

    drain();
    repeat (200) @(posedge clk_i);
    for (int i = 0; i < sb.pending(); i++) sb.report("result never arrived", 0, 1);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
